@@ hdl/mtgp_pkg.sv @@
// package for the map tile grid placement block: constants, tables and helpers
`timescale 1ns / 1ps
package mtgp_pkg;

  localparam int MAX_ZOOM  = 10;
  localparam int GRID_HALF = 2;
  localparam int GRID_N    = 2 * GRID_HALF + 1;

  localparam logic signed [23:0] LAT_LIMIT   = 24'sd5573911;
  localparam logic [22:0]        LAT_85      = 23'd5570560;
  localparam logic signed [25:0] LON_OFFSET  = 26'sd11796480;
  localparam logic signed [25:0] LON_TURN    = 26'sd23592960;
  localparam logic [19:0]        EARTH_16    = 20'd641200;
  localparam logic [15:0]        INV_SQRT2   = 16'd46341;
  localparam logic [16:0]        COS_FLOOR   = 17'd6554;
  localparam logic [25:0]        ONE_Q24     = 26'd16777216;
  localparam logic [21:0]        MERC_LAST_D = 22'd54924;

  // reciprocals for constant division
  localparam logic [25:0] RCP45_25   = 26'd47721859;   // >> 31
  localparam logic [21:0] RCP45_21   = 22'd2982617;    // >> 27
  localparam logic [15:0] RCP5_16    = 16'd52429;      // >> 18
  localparam logic [31:0] RCP5_32    = 32'd3435973837; // >> 34
  localparam logic [28:0] RCP3351_28 = 29'd328114482;  // >> 40

  function automatic logic [16:0] cos_lut(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd65287;
      5'd2:    v = 17'd64540;
      5'd3:    v = 17'd63303;
      5'd4:    v = 17'd61584;
      5'd5:    v = 17'd59396;
      5'd6:    v = 17'd56755;
      5'd7:    v = 17'd53684;
      5'd8:    v = 17'd50203;
      5'd9:    v = 17'd46341;
      5'd10:   v = 17'd42126;
      5'd11:   v = 17'd37590;
      5'd12:   v = 17'd32768;
      5'd13:   v = 17'd27697;
      5'd14:   v = 17'd22415;
      5'd15:   v = 17'd16962;
      5'd16:   v = 17'd11380;
      5'd17:   v = 17'd5712;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic [24:0] merc_lut(input logic [4:0] idx);
    logic [24:0] v;
    case (idx)
      5'd0:    v = 25'd0;
      5'd1:    v = 25'd466678;
      5'd2:    v = 25'd936836;
      5'd3:    v = 25'd1414353;
      5'd4:    v = 25'd1903194;
      5'd5:    v = 25'd2407806;
      5'd6:    v = 25'd2933488;
      5'd7:    v = 25'd3486280;
      5'd8:    v = 25'd4074204;
      5'd9:    v = 25'd4706835;
      5'd10:   v = 25'd5397402;
      5'd11:   v = 25'd6164058;
      5'd12:   v = 25'd7033024;
      5'd13:   v = 25'd8044886;
      5'd14:   v = 25'd9267731;
      5'd15:   v = 25'd10828525;
      5'd16:   v = 25'd13010419;
      5'd17:   v = 25'd16722292;
      default: v = 25'd16777216;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/map_tile_grid_placement.sv @@
// top level: view request to a grid of web mercator tiles with pixel positions
// throughput: the tile emitter sends a full grid per request, one tile per cycle while m_tready is high
// the nine math stages accept a request every cycle and hold while the emitter is busy
// reset: synchronous active-high rst clears all valid bits and the emitter
`timescale 1ns / 1ps
module map_tile_grid_placement
  import mtgp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // center_longitude[24:0], center_latitude[48:25], view_radius[68:49]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // tile_column[9:0], tile_row[21:10], pixel_left[32:22],
                                 // pixel_top[43:33], zoom_level[47:44]
  output logic        m_tlast    // last_tile
);

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic en1, en2, en3, en4, en5, en6, en7, en8, en9;

  // stage 1
  logic [24:0] s1_u;
  logic [22:0] s1_a;
  logic        s1_neg;
  logic [19:0] s1_r;
  // stage 2
  logic [24:0] s2_u;
  logic [18:0] s2_f, s2_fm;
  logic        s2_hi, s2_neg;
  logic [16:0] s2_cos_i;
  logic [12:0] s2_cos_d;
  logic [24:0] s2_merc_b;
  logic [21:0] s2_merc_d;
  logic [50:0] s2_uq;
  logic [35:0] s2_rhs;
  // stage 3
  logic [31:0] s3_cprod;
  logic [40:0] s3_mprod;
  logic [18:0] s3_q0;
  logic [5:0]  s3_r0;
  logic [16:0] s3_cos_i;
  logic [24:0] s3_merc_b;
  logic        s3_hi, s3_neg;
  logic [35:0] s3_rhs;
  // stage 4
  logic [32:0] s4_cq;
  logic [57:0] s4_mq;
  logic [18:0] s4_q0;
  logic [5:0]  s4_r0;
  logic [16:0] s4_cos_i;
  logic [24:0] s4_merc_b;
  logic        s4_hi, s4_neg;
  logic [35:0] s4_rhs;
  // stage 5
  logic [16:0] s5_c;
  logic [24:0] s5_m;
  logic [18:0] s5_q0;
  logic [5:0]  s5_r0;
  logic        s5_neg;
  logic [35:0] s5_rhs;
  // stage 6
  logic [36:0] s6_lhs;
  logic [24:0] s6_m;
  logic [18:0] s6_q0;
  logic [5:0]  s6_r0;
  logic        s6_neg;
  logic [35:0] s6_rhs;
  // stage 7
  logic [3:0]  s7_z;
  logic [24:0] s7_m;
  logic [18:0] s7_q0;
  logic [5:0]  s7_r0;
  logic        s7_neg;
  // stage 8
  logic [3:0]  s8_z;
  logic [35:0] s8_yfix;
  logic [42:0] s8_tprod;
  logic [33:0] s8_xhi;
  // stage 9
  logic [3:0]        s9_z;
  logic [9:0]        s9_cx;
  logic [10:0]       s9_cy;
  logic signed [9:0] s9_gx, s9_gy;

  // emitter
  logic              busy;
  logic [2:0]        dxi, dyi;
  logic [3:0]        j_z;
  logic [9:0]        j_cx, j_mask;
  logic [10:0]       j_cy;
  logic signed [9:0] j_gx, j_gy;
  logic              out_ready, last_pos, job_take;

  assign out_ready = !m_tvalid || m_tready;
  assign last_pos  = (dxi == 3'(GRID_N - 1)) && (dyi == 3'(GRID_N - 1));
  assign job_take  = v9 && (!busy || (out_ready && last_pos));
  assign en9 = !v9 || job_take;
  assign en8 = !v8 || en9;
  assign en7 = !v7 || en8;
  assign en6 = !v6 || en7;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  // stage 1 logic
  logic signed [24:0] in_lon;
  logic signed [23:0] in_lat, lat_sat;
  logic signed [25:0] lon_ofs, lon_w;
  assign in_lon  = s_tdata[24:0];
  assign in_lat  = s_tdata[48:25];
  assign lat_sat = (in_lat > LAT_LIMIT) ? LAT_LIMIT :
                   (in_lat < -LAT_LIMIT) ? -LAT_LIMIT : in_lat;
  assign lon_ofs = 26'(in_lon) + LON_OFFSET;
  assign lon_w   = (lon_ofs < 0) ? lon_ofs + LON_TURN :
                   (lon_ofs >= LON_TURN) ? lon_ofs - LON_TURN : lon_ofs;

  // stage 2 logic
  logic [4:0]  seg;
  logic [16:0] seg_mul;
  logic [18:0] seg_f;
  logic        seg_hi;
  assign seg     = 5'((17'(s1_a[22:16]) * 17'd205) >> 10);
  assign seg_mul = 17'(seg) * 17'd5;
  assign seg_f   = 19'(s1_a - {seg_mul[6:0], 16'd0});
  assign seg_hi  = s1_a >= LAT_85;

  // stage 5 logic
  logic [16:0] cos_raw;
  assign cos_raw = s4_cos_i - 17'(s4_cq[32:18]);

  // stage 7 logic
  logic [3:0] zcnt;
  always_comb begin
    zcnt = '0;
    for (int k = 1; k <= MAX_ZOOM; k++) begin
      if ({10'd0, s6_lhs} >= ({11'd0, s6_rhs} << k)) zcnt = zcnt + 4'd1;
    end
  end

  // stage 8 logic
  logic [25:0] ybase;
  logic [20:0] rn;
  assign ybase = s7_neg ? ONE_Q24 + 26'(s7_m) : ONE_Q24 - 26'(s7_m);
  assign rn    = 21'(s7_r0) << (s7_z + 4'd5);

  // stage 9 logic
  logic [34:0] xfix;
  logic [24:0] gxr, gyr;
  assign xfix = 35'(s8_xhi) + 35'(s8_tprod[42:27]);
  assign gxr  = ONE_Q24[24:0] - {1'b0, xfix[23:0]};
  assign gyr  = ONE_Q24[24:0] - {1'b0, s8_yfix[23:0]};

  // tile fields
  logic signed [3:0]  dx, dy;
  logic signed [11:0] left_w, top_w;
  logic [9:0]         col;
  logic [11:0]        row;
  assign dx     = 4'(signed'({1'b0, dxi})) - 4'(GRID_HALF);
  assign dy     = 4'(signed'({1'b0, dyi})) - 4'(GRID_HALF);
  assign col    = (j_cx + 10'(dx)) & j_mask;
  assign row    = 12'(j_cy) + 12'(dy);
  assign left_w = 12'(j_gx) + 12'(dx) * 12'sd257 + 12'sd256;
  assign top_w  = 12'(j_gy) + 12'(dy) * 12'sd257 + 12'sd256;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
      busy <= 1'b0;
      dxi <= '0;
      dyi <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
      if (en8) v8 <= v7;
      if (en9) v9 <= v8;
      if (out_ready) m_tvalid <= busy;
      if (job_take) begin
        busy <= 1'b1;
        dxi <= '0;
        dyi <= '0;
      end else if (busy && out_ready) begin
        if (last_pos) begin
          busy <= 1'b0;
        end else if (dyi == 3'(GRID_N - 1)) begin
          dyi <= '0;
          dxi <= dxi + 3'd1;
        end else begin
          dyi <= dyi + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_u   <= 25'(lon_w);
      s1_a   <= 23'(lat_sat < 0 ? -lat_sat : lat_sat);
      s1_neg <= lat_sat < 0;
      s1_r   <= s_tdata[68:49];
    end
    if (en2) begin
      s2_u      <= s1_u;
      s2_f      <= seg_f;
      s2_fm     <= seg_hi ? 19'(s1_a - LAT_85) : seg_f;
      s2_hi     <= seg_hi;
      s2_neg    <= s1_neg;
      s2_cos_i  <= cos_lut(seg);
      s2_cos_d  <= 13'(cos_lut(seg) - cos_lut(seg + 5'd1));
      s2_merc_b <= seg_hi ? merc_lut(5'd17) : merc_lut(seg);
      s2_merc_d <= seg_hi ? MERC_LAST_D : 22'(merc_lut(seg + 5'd1) - merc_lut(seg));
      s2_uq     <= 51'(s1_u) * 51'(RCP45_25);
      s2_rhs    <= 36'(s1_r) * 36'(INV_SQRT2);
    end
    if (en3) begin
      s3_cprod  <= 32'(s2_cos_d) * 32'(s2_f);
      s3_mprod  <= 41'(s2_merc_d) * 41'(s2_fm);
      s3_q0     <= s2_uq[49:31];
      s3_r0     <= 6'(s2_u - 25'(s2_uq[49:31]) * 25'd45);
      s3_cos_i  <= s2_cos_i;
      s3_merc_b <= s2_merc_b;
      s3_hi     <= s2_hi;
      s3_neg    <= s2_neg;
      s3_rhs    <= s2_rhs;
    end
    if (en4) begin
      s4_cq     <= 33'(s3_cprod[31:16]) * 33'(RCP5_16);
      s4_mq     <= s3_hi ? 58'(s3_mprod[27:0]) * 58'(RCP3351_28)
                         : 58'(s3_mprod[40:16]) * 58'(RCP5_32);
      s4_q0     <= s3_q0;
      s4_r0     <= s3_r0;
      s4_cos_i  <= s3_cos_i;
      s4_merc_b <= s3_merc_b;
      s4_hi     <= s3_hi;
      s4_neg    <= s3_neg;
      s4_rhs    <= s3_rhs;
    end
    if (en5) begin
      s5_c   <= (cos_raw < COS_FLOOR) ? COS_FLOOR : cos_raw;
      s5_m   <= s4_merc_b + (s4_hi ? 25'(s4_mq[57:40]) : 25'(s4_mq[57:34]));
      s5_q0  <= s4_q0;
      s5_r0  <= s4_r0;
      s5_neg <= s4_neg;
      s5_rhs <= s4_rhs;
    end
    if (en6) begin
      s6_lhs <= 37'(s5_c) * 37'(EARTH_16);
      s6_m   <= s5_m;
      s6_q0  <= s5_q0;
      s6_r0  <= s5_r0;
      s6_neg <= s5_neg;
      s6_rhs <= s5_rhs;
    end
    if (en7) begin
      s7_z   <= zcnt;
      s7_m   <= s6_m;
      s7_q0  <= s6_q0;
      s7_r0  <= s6_r0;
      s7_neg <= s6_neg;
    end
    if (en8) begin
      s8_z     <= s7_z;
      s8_yfix  <= (36'(ybase) << s7_z) >> 1;
      s8_tprod <= 43'(rn) * 43'(RCP45_21);
      s8_xhi   <= 34'(s7_q0) << (s7_z + 4'd5);
    end
    if (en9) begin
      s9_z  <= s8_z;
      s9_cx <= xfix[33:24];
      s9_cy <= s8_yfix[34:24];
      s9_gx <= 10'(signed'({1'b0, gxr[24:16]})) - 10'sd128;
      s9_gy <= 10'(signed'({1'b0, gyr[24:16]})) - 10'sd128;
    end
    if (job_take) begin
      j_z    <= s9_z;
      j_cx   <= s9_cx;
      j_cy   <= s9_cy;
      j_gx   <= s9_gx;
      j_gy   <= s9_gy;
      j_mask <= 10'((11'd1 << s9_z) - 11'd1);
    end
    if (busy && out_ready) begin
      m_tdata <= {j_z, top_w[10:0], left_w[10:0], row, col};
      m_tlast <= last_pos;
    end
  end

endmodule
